// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of the project.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LDPH_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// expression must never be true outside reset
`define LDPH_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/ldph_pkg.sv =====
// Shared types and constants of the lattice density profile histogram.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ldph_pkg;

    localparam int GRID_DEF      = 64;
    localparam int BIN_DEPTH_DEF = 256;

    localparam int CNT_W  = 19;
    localparam int FRAC_W = 17;
    localparam int POS_W  = 8;
    localparam int TYPE_W = 4;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 4;
    localparam int REM_W  = CNT_W + 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = 19'd262144;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic [1:0] REG_TYPE_A = 2'd0;
    localparam logic [1:0] REG_TYPE_B = 2'd1;
    localparam logic [1:0] REG_AXIS   = 2'd2;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic upd_en;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mem_op;
        logic div_busy;
        logic out_free;
    } ctrl_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ldph_div.sv =====
// Sequential restoring divider for the Q1.16 target fraction, one bit a cycle.
// Depends on ldph_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ldph_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [ldph_pkg::CNT_W-1:0]  num,
    input  wire logic [ldph_pkg::CNT_W-1:0]  den,
    output logic                             busy,
    output logic [ldph_pkg::FRAC_W-1:0]      quo
);
    localparam int STEP_W = $clog2(ldph_pkg::FRAC_W + 1);

    logic [ldph_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [ldph_pkg::CNT_W-1:0]  den_reg;
    logic [ldph_pkg::FRAC_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        ge;
    logic [ldph_pkg::REM_W-1:0]  rem_sub;

    assign ge      = rem_reg >= {1'b0, den_reg};
    assign rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = {1'b0, num};
            quo_next  = '0;
            step_next = STEP_W'(ldph_pkg::FRAC_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = {rem_sub[ldph_pkg::REM_W-2:0], 1'b0};
            quo_next  = {quo_reg[ldph_pkg::FRAC_W-2:0], ge};
            step_next = step_reg - 1'b1;
            busy_next = step_reg != STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/ldph_ctrl.sv =====
// Control FSM: accept, bin read, update/divide (in-range add/query), output.
// Depends on ldph_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ldph_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire ldph_pkg::ctrl_status_t   status,
    output ldph_pkg::ctrl_cmd_t           cmd
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = status.mem_op ? ST_UPD : ST_DONE;
            end
            ST_UPD: begin
                cmd.upd_en = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ldph_dpath.sv =====
// Datapath: config registers, bin address, count memory with valid bits,
// divider and output register. Depends on ldph_pkg and ldph_div.
`timescale 1ns / 1ps
`default_nettype none
module ldph_dpath #(
    parameter int GRID      = ldph_pkg::GRID_DEF,
    parameter int BIN_DEPTH = ldph_pkg::BIN_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [31:0]                 s_tdata,
    input  wire logic [1:0]                  s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [63:0]                      m_tdata,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_addr,
    input  wire logic [ldph_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire ldph_pkg::ctrl_cmd_t         cmd,
    output ldph_pkg::ctrl_status_t           status
);
    localparam int AW    = $clog2(BIN_DEPTH);
    localparam int BIN_W = 10;
    localparam int CW    = ldph_pkg::CNT_W;

    logic [ldph_pkg::TYPE_W-1:0] type_a_reg, type_b_reg;
    logic [1:0]                  axis_reg;

    logic [ldph_pkg::TYPE_W-1:0] in_type;
    logic [ldph_pkg::IDX_W-1:0]  in_i, in_j, in_k;
    logic [ldph_pkg::POS_W-1:0]  in_qbin;
    logic [8:0]                  ei, ej, ek, sum9;
    logic [ldph_pkg::POS_W-1:0]  pos_in;
    logic [BIN_W-1:0]            bin;
    logic                        in_range;

    logic [ldph_pkg::POS_W-1:0]  pos_reg;
    logic [AW-1:0]               addr_reg;
    logic                        mem_op_reg, add_reg, hit_reg;

    logic [2*CW-1:0]             mem [BIN_DEPTH];
    logic [BIN_DEPTH-1:0]        valid_reg;
    logic [2*CW-1:0]             rd_data_reg;
    logic                        rd_valid_reg;

    logic [CW-1:0]               tot_cur, tgt_cur, tot_new, tgt_new, tot_use, tgt_use;
    logic [CW-1:0]               tot_reg, tgt_reg;

    logic                        div_busy;
    logic [ldph_pkg::FRAC_W-1:0] div_quo;

    logic                        m_valid_reg;
    logic [63:0]                 m_data_reg;
    logic                        present;

    assign in_type = s_tdata[3:0];
    assign in_i    = s_tdata[9:4];
    assign in_j    = s_tdata[15:10];
    assign in_k    = s_tdata[21:16];
    assign in_qbin = s_tdata[29:22];

    assign ei = {3'b000, in_i};
    assign ej = {3'b000, in_j};
    assign ek = {3'b000, in_k};

    always_comb begin
        if (axis_reg == ldph_pkg::AXIS_X) begin
            sum9 = ej + ek - ei;
        end else if (axis_reg == ldph_pkg::AXIS_Y) begin
            sum9 = ei + ek - ej;
        end else begin
            sum9 = ei + ej - ek;
        end
        pos_in   = (s_tuser == ldph_pkg::OP_ADD) ? sum9[7:0] : in_qbin;
        bin      = {{(BIN_W-ldph_pkg::POS_W){pos_in[7]}}, pos_in} + BIN_W'(GRID - 1);
        in_range = !bin[BIN_W-1] && (bin[8:0] < 9'(BIN_DEPTH));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_a_reg <= 4'hF;
            type_b_reg <= 4'h3;
            axis_reg   <= ldph_pkg::AXIS_X;
        end else if (cfg_we) begin
            case (cfg_addr)
                ldph_pkg::REG_TYPE_A: type_a_reg <= cfg_wdata;
                ldph_pkg::REG_TYPE_B: type_b_reg <= cfg_wdata;
                ldph_pkg::REG_AXIS:   axis_reg   <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // request latch
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mem_op_reg <= ((s_tuser == ldph_pkg::OP_ADD) || (s_tuser == ldph_pkg::OP_QUERY))
                          && in_range;
            add_reg    <= s_tuser == ldph_pkg::OP_ADD;
            hit_reg    <= (in_type == type_a_reg) || (in_type == type_b_reg);
            addr_reg   <= bin[AW-1:0];
            pos_reg    <= ((s_tuser == ldph_pkg::OP_ADD) || (s_tuser == ldph_pkg::OP_QUERY))
                          ? pos_in : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.accept && (s_tuser == ldph_pkg::OP_CLEAR)) begin
            valid_reg <= '0;
        end else if (cmd.upd_en && add_reg) begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd_en && add_reg) begin
            mem[addr_reg] <= {tgt_new, tot_new};
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[addr_reg];
            rd_valid_reg <= valid_reg[addr_reg];
        end
    end

    always_comb begin
        tot_cur = rd_valid_reg ? rd_data_reg[CW-1:0] : '0;
        tgt_cur = rd_valid_reg ? rd_data_reg[2*CW-1:CW] : '0;
        tot_new = tot_cur;
        tgt_new = tgt_cur;
        if (tot_cur < ldph_pkg::COUNT_MAX) begin
            tot_new = tot_cur + 1'b1;
            tgt_new = tgt_cur + CW'(hit_reg);
        end
        tot_use = add_reg ? tot_new : tot_cur;
        tgt_use = add_reg ? tgt_new : tgt_cur;
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd_en) begin
            tot_reg <= tot_use;
            tgt_reg <= tgt_use;
        end
    end

    ldph_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.upd_en),
        .num     (tgt_use),
        .den     (tot_use),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    assign present = mem_op_reg && (tot_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_data_reg <= {present,
                           present ? div_quo : {ldph_pkg::FRAC_W{1'b0}},
                           mem_op_reg ? tgt_reg : {CW{1'b0}},
                           mem_op_reg ? tot_reg : {CW{1'b0}},
                           pos_reg};
        end
    end

    assign status.mem_op   = mem_op_reg;
    assign status.div_busy = div_busy;
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/lattice_density_profile_histogram_top.sv =====
// Add/query in range: result registered after accept, bin read, update and the
// 17-step fraction divider; clear, reserved op, out of range: after bin read.
// Next request is taken the cycle after the result is loaded into the output
// register, even while that result still waits for m_tready.
// aresetn (synchronous, active low) restores config defaults and clears all
// bins at once through per-bin valid bits.
`timescale 1ns / 1ps
`default_nettype none
module lattice_density_profile_histogram_top #(
    parameter int GRID      = ldph_pkg::GRID_DEF,
    parameter int BIN_DEPTH = ldph_pkg::BIN_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // site_type[3:0], index_i[9:4], index_j[15:10], index_k[21:16],
    // query_bin[29:22], zero[31:30]
    input  wire logic [31:0]                 s_tdata,
    // op[1:0]
    input  wire logic [1:0]                  s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // bin_position_x2[7:0], bin_total[26:8], bin_target[45:27],
    // target_fraction[62:46], bin_present[63]
    output logic [63:0]                      m_tdata,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_addr,
    input  wire logic [ldph_pkg::CFG_W-1:0]  cfg_wdata
);
    ldph_pkg::ctrl_cmd_t    cmd;
    ldph_pkg::ctrl_status_t status;

    ldph_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ldph_dpath #(
        .GRID      (GRID),
        .BIN_DEPTH (BIN_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/ldph_checker.sv =====
// Port-level checker for the histogram top level, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ldph_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);
    `LDPH_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `LDPH_ASSERT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `LDPH_ASSERT_NEVER(a_present_empty, aclk, aresetn, m_tvalid && m_tdata[63] && (m_tdata[26:8] == 19'd0))
    `LDPH_ASSERT_NEVER(a_target_gt_total, aclk, aresetn, m_tvalid && (m_tdata[45:27] > m_tdata[26:8]))
    `LDPH_ASSERT_NEVER(a_frac_absent, aclk, aresetn, m_tvalid && !m_tdata[63] && (m_tdata[62:46] != 17'd0))
endmodule

bind lattice_density_profile_histogram_top ldph_checker u_ldph_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/sv/lattice_density_profile_histogram_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lattice_density_profile_histogram_top: a table of
// directed requests, then random requests under five register settings.
// Needs ldph_pkg and the top level only.
module lattice_density_profile_histogram_top_tb;
    import ldph_pkg::*;

    localparam int GRID            = GRID_DEF;
    localparam int BIN_DEPTH       = BIN_DEPTH_DEF;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 8;
    localparam int NUM_PROBES      = 22;
    localparam int NUM_SETTINGS    = 5;
    localparam int REQS_PER_SET    = 250;
    localparam int SETTLE_CYCLES   = 24;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int WATCHDOG_CYCLES = 3000;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [1:0] AXIS_Z      = 2'd2;
    localparam logic [1:0] AXIS_Z_ALT  = 2'd3;

    // first member lands in the top bits, so this matches m_tdata as laid out
    typedef struct packed {
        logic              present;
        logic [FRAC_W-1:0] frac;
        logic [CNT_W-1:0]  target;
        logic [CNT_W-1:0]  total;
        logic [POS_W-1:0]  pos;
    } bin_report_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] data;
        logic        fixed;
        bin_report_t want;
    } probe_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    // mirror of the block's registers and bin memory
    logic [TYPE_W-1:0] type_a   = 4'hF;
    logic [TYPE_W-1:0] type_b   = 4'h3;
    logic [1:0]        axis_sel = AXIS_X;
    logic [CNT_W-1:0]  site_total  [BIN_DEPTH];
    logic [CNT_W-1:0]  site_target [BIN_DEPTH];

    bin_report_t       pending_reports[$];
    logic [POS_W-1:0]  touched_pos[$];
    probe_row_t        probe_rows[NUM_PROBES];

    logic        pend_fixed;
    bin_report_t pend_want;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          rx_hold_req = 1'b0;
    int          n_errors = 0;
    int          n_results = 0;
    int          op_seen[4] = '{0, 0, 0, 0};
    int          quiet_cycles = 0;

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    lattice_density_profile_histogram_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    function automatic logic [31:0] pack_site(input logic [3:0] st, input logic [5:0] ii,
                                              input logic [5:0] jj, input logic [5:0] kk,
                                              input logic [7:0] qb);
        return {2'b00, qb, kk, jj, ii, st};
    endfunction

    function automatic bin_report_t mk_report(input logic [7:0] pos, input logic [18:0] tot,
                                              input logic [18:0] tgt, input logic [16:0] frac,
                                              input logic present);
        bin_report_t r;
        r.pos     = pos;
        r.total   = tot;
        r.target  = tgt;
        r.frac    = frac;
        r.present = present;
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 0;
        if (r < 80) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(12, 4);
        return $urandom_range(64, 24);
    endfunction

    // updates the bin mirror and returns the report the block should give
    function automatic bin_report_t predict_bin_report(input logic [1:0] op,
                                                       input logic [31:0] d);
        bin_report_t r;
        int ii, jj, kk, pos, idx;
        logic [63:0] num;
        r = '0;
        ii = d[9:4];
        jj = d[15:10];
        kk = d[21:16];
        pos = 0;
        case (op)
            OP_ADD: begin
                case (axis_sel)
                    AXIS_X:  pos = -ii + jj + kk;
                    AXIS_Y:  pos = ii - jj + kk;
                    default: pos = ii + jj - kk;
                endcase
            end
            OP_QUERY: pos = $signed(d[29:22]);
            OP_CLEAR: begin
                for (int b = 0; b < BIN_DEPTH; b++) begin
                    site_total[b]  = '0;
                    site_target[b] = '0;
                end
            end
            default: ;
        endcase
        if (op == OP_ADD || op == OP_QUERY) begin
            r.pos = pos[7:0];
            idx = pos + GRID - 1;
            if (idx >= 0 && idx < BIN_DEPTH) begin
                if (op == OP_ADD && site_total[idx] < COUNT_MAX) begin
                    site_total[idx]++;
                    if (d[3:0] == type_a || d[3:0] == type_b)
                        site_target[idx]++;
                end
                r.total  = site_total[idx];
                r.target = site_target[idx];
                if (site_total[idx] != '0) begin
                    num = 64'(site_target[idx]) << 16;
                    r.frac = 17'(num / 64'(site_total[idx]));
                    r.present = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic bit field_bad(input string name, input int unsigned want,
                                     input int unsigned got);
        if (want == got) return 1'b0;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        return 1'b1;
    endfunction

    task automatic offer_request(input logic [1:0] op, input logic [31:0] data,
                                 input logic fixed, input bin_report_t want);
        int gap;
        gap = tx_idle ? idle_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= op;
        s_tdata    <= data;
        pend_fixed <= fixed;
        pend_want  <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic make_random_request(output logic [1:0] op, output logic [31:0] data);
        int r;
        logic [3:0] st;
        logic [5:0] ii, jj, kk;
        logic [7:0] qb;
        r = $urandom_range(99);
        if (r < 58) op = OP_ADD;
        else if (r < 96) op = OP_QUERY;
        else if (r < 97) op = OP_CLEAR;
        else op = OP_RESERVED;
        r = $urandom_range(3);
        st = (r == 0) ? type_a : (r == 1) ? type_b : 4'($urandom);
        // clustered indices pile sites into a few bins
        ii = $urandom_range(1) ? 6'($urandom_range(3)) : 6'($urandom);
        jj = $urandom_range(1) ? 6'($urandom_range(3)) : 6'($urandom);
        kk = $urandom_range(1) ? 6'($urandom_range(3)) : 6'($urandom);
        r = $urandom_range(99);
        if (op == OP_QUERY && r < 50 && touched_pos.size() > 0)
            qb = touched_pos[$urandom_range(touched_pos.size() - 1)];
        else if (op == OP_QUERY && r < 85)
            qb = 8'($urandom_range(189) - 63);
        else
            qb = 8'($urandom);
        data = pack_site(st, ii, jj, kk, qb);
    endtask

    task automatic load_config(input logic [3:0] new_a, input logic [3:0] new_b,
                               input logic [1:0] new_axis);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_TYPE_A;
        cfg_wdata <= new_a;
        @(posedge aclk);
        cfg_addr  <= REG_TYPE_B;
        cfg_wdata <= new_b;
        @(posedge aclk);
        cfg_addr  <= REG_AXIS;
        cfg_wdata <= {2'b00, new_axis};
        @(posedge aclk);
        cfg_we   <= 1'b0;
        type_a   = new_a;
        type_b   = new_b;
        axis_sel = new_axis;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        // wait for the clock so the last accepted request is already queued
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // request side: predict at acceptance
    always @(posedge aclk) begin
        bin_report_t r;
        if (aresetn && s_tvalid && s_tready) begin
            r = predict_bin_report(s_tuser, s_tdata);
            op_seen[s_tuser]++;
            if (s_tuser == OP_ADD) begin
                touched_pos.push_back(r.pos);
                if (touched_pos.size() > 32) void'(touched_pos.pop_front());
            end
            pending_reports.push_back(pend_fixed ? pend_want : r);
        end
    end

    // result side
    always @(posedge aclk) begin
        bin_report_t got, want;
        bit bad;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            n_results++;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_tdata);
                n_errors++;
            end else begin
                want = pending_reports.pop_front();
                bad = field_bad("bin_position_x2", want.pos, got.pos);
                bad |= field_bad("bin_total", want.total, got.total);
                bad |= field_bad("bin_target", want.target, got.target);
                bad |= field_bad("target_fraction", want.frac, got.frac);
                bad |= field_bad("bin_present", want.present, got.present);
                if (bad) n_errors++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("lattice_density_profile_histogram_top regression: fail");
                $finish;
            end
        end
    end

    // result receiver
    initial begin
        int stall;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = rx_idle ? idle_gap() : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic [1:0]  op;
        logic [31:0] data;
        logic [3:0]  new_a, new_b;
        logic [1:0]  new_axis;

        for (int b = 0; b < BIN_DEPTH; b++) begin
            site_total[b]  = '0;
            site_target[b] = '0;
        end
        probe_rows[0]  = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'h00), 1'b1,
                          mk_report(8'h00, 0, 0, 0, 1'b0)};
        probe_rows[1]  = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'hC1), 1'b1,
                          mk_report(8'hC1, 0, 0, 0, 1'b0)};
        probe_rows[2]  = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'h7E), 1'b1,
                          mk_report(8'h7E, 0, 0, 0, 1'b0)};
        probe_rows[3]  = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'h7F), 1'b1,
                          mk_report(8'h7F, 0, 0, 0, 1'b0)};
        // below the bottom bin
        probe_rows[4]  = {OP_QUERY, pack_site(4'hF, 6'd63, 6'd63, 6'd63, 8'hC0), 1'b1,
                          mk_report(8'hC0, 0, 0, 0, 1'b0)};
        probe_rows[5]  = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'h80), 1'b1,
                          mk_report(8'h80, 0, 0, 0, 1'b0)};
        probe_rows[6]  = {OP_ADD, pack_site(4'hF, 6'd0, 6'd0, 6'd0, 8'h00), 1'b1,
                          mk_report(8'h00, 1, 1, 17'd65536, 1'b1)};
        probe_rows[7]  = {OP_ADD, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'hFF), 1'b1,
                          mk_report(8'h00, 2, 1, 17'd32768, 1'b1)};
        probe_rows[8]  = {OP_ADD, pack_site(4'h3, 6'd63, 6'd0, 6'd0, 8'h00), 1'b1,
                          mk_report(8'hC1, 1, 1, 17'd65536, 1'b1)};
        probe_rows[9]  = {OP_ADD, pack_site(4'h7, 6'd0, 6'd63, 6'd63, 8'h00), 1'b1,
                          mk_report(8'h7E, 1, 0, 0, 1'b1)};
        probe_rows[10] = {OP_ADD, pack_site(4'h8, 6'd63, 6'd63, 6'd63, 8'h00), 1'b1,
                          mk_report(8'h3F, 1, 0, 0, 1'b1)};
        probe_rows[11] = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'h00), 1'b1,
                          mk_report(8'h00, 2, 1, 17'd32768, 1'b1)};
        probe_rows[12] = {OP_ADD, pack_site(4'h3, 6'd0, 6'd0, 6'd0, 8'h00), 1'b1,
                          mk_report(8'h00, 3, 2, 17'd43690, 1'b1)};
        probe_rows[13] = {OP_RESERVED, 32'h3FFF_FFFF, 1'b1, mk_report(8'h00, 0, 0, 0, 1'b0)};
        probe_rows[14] = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'h7E), 1'b1,
                          mk_report(8'h7E, 1, 0, 0, 1'b1)};
        probe_rows[15] = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'h3F), 1'b1,
                          mk_report(8'h3F, 1, 0, 0, 1'b1)};
        probe_rows[16] = {OP_CLEAR, pack_site(4'h5, 6'd7, 6'd9, 6'd11, 8'h00), 1'b1,
                          mk_report(8'h00, 0, 0, 0, 1'b0)};
        probe_rows[17] = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'h00), 1'b1,
                          mk_report(8'h00, 0, 0, 0, 1'b0)};
        probe_rows[18] = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'hC1), 1'b1,
                          mk_report(8'hC1, 0, 0, 0, 1'b0)};
        probe_rows[19] = {OP_ADD, pack_site(4'h5, 6'd10, 6'd20, 6'd30, 8'h00), 1'b0, 64'd0};
        probe_rows[20] = {OP_ADD, pack_site(4'hF, 6'd10, 6'd20, 6'd30, 8'h00), 1'b0, 64'd0};
        probe_rows[21] = {OP_QUERY, pack_site(4'h0, 6'd0, 6'd0, 6'd0, 8'd40), 1'b0, 64'd0};

        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= OP_ADD;
        pend_fixed <= 1'b0;
        pend_want  <= '0;
        cfg_we     <= 1'b0;
        cfg_addr   <= REG_TYPE_A;
        cfg_wdata  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < NUM_PROBES; p++)
            offer_request(probe_rows[p].op, probe_rows[p].data, probe_rows[p].fixed,
                          probe_rows[p].want);
        drain();

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            if (ph > 0) begin
                case (ph)
                    1: begin
                        new_a = 4'h8;
                        new_b = 4'h7;
                        new_axis = AXIS_Y;
                    end
                    2: begin
                        new_a = 4'h7;
                        new_b = 4'h8;
                        new_axis = AXIS_Z;
                    end
                    3: begin
                        new_a = 4'h0;
                        new_b = 4'h0;
                        new_axis = AXIS_Z_ALT;
                    end
                    default: begin
                        new_a = 4'($urandom);
                        new_b = 4'($urandom);
                        new_axis = 2'($urandom);
                    end
                endcase
                load_config(new_a, new_b, new_axis);
            end
            // back-to-back traffic on both sides for one setting
            tx_idle = (ph != 3);
            rx_idle = (ph != 3);
            for (int n = 0; n < REQS_PER_SET; n++) begin
                if (ph == 2 && n == 100) rx_hold_req = 1'b1;
                make_random_request(op, data);
                offer_request(op, data, 1'b0, '0);
            end
            drain();
        end

        $display("Covered %0d adds, %0d queries, %0d clears, %0d reserved requests",
                 op_seen[OP_ADD], op_seen[OP_QUERY], op_seen[OP_CLEAR], op_seen[OP_RESERVED]);
        $display("over %0d register settings; %0d results checked, %0d bad",
                 NUM_SETTINGS, n_results, n_errors);
        if (n_errors == 0)
            $display("lattice_density_profile_histogram_top regression: pass");
        else
            $display("lattice_density_profile_histogram_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ldph_pkg.sv
hw/rtl/ldph_div.sv
hw/rtl/ldph_ctrl.sv
hw/rtl/ldph_dpath.sv
hw/rtl/lattice_density_profile_histogram_top.sv
hw/rtl/ldph_checker.sv
tb/sv/lattice_density_profile_histogram_top_tb.sv
